[hw/rtl/rsf_pkg.sv]
// ----------------------------------------------------------------------------
// rsf_pkg
// shared types and codes for the run-length sprite pixel fetch block
// ----------------------------------------------------------------------------
package rsf_pkg;

    // item kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // run byte fields
    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [7:0] RUN_LEN_MASK = 8'h7F;
    localparam logic [7:0] ROW_END      = 8'h00;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_X_OUTSIDE = 3'd2;
    localparam logic [2:0] ST_Y_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_ROW_ENDED = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SKIP = 2'd1,
        PH_SCAN = 2'd2
    } t_phase;

    typedef struct packed {
        logic        mode;
        logic [15:0] subimage_index;
        logic [15:0] sub_width;
        logic [15:0] sub_height;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel;
        logic [2:0] status;
    } t_out_item;

    // decoder context carried from one item to the next
    typedef struct packed {
        t_phase      phase;
        logic [15:0] row_count;
        logic [15:0] column_count;
        logic [6:0]  literal_left;
        logic [15:0] want_x;
        logic [15:0] want_y;
    } t_ctx;

endpackage

[hw/rtl/rsf_core.sv]
// ----------------------------------------------------------------------------
// rsf_core
// one-item step of the run-length decoder: next context and optional result
// ----------------------------------------------------------------------------
module rsf_core (
    input  rsf_pkg::t_ctx      i_ctx,
    input  rsf_pkg::t_in_item  i_item,
    input  logic [15:0]        i_subimage_count,
    output rsf_pkg::t_ctx      o_ctx,
    output logic               o_res_valid,
    output rsf_pkg::t_out_item o_res
);
    import rsf_pkg::*;

    logic [7:0]  b;
    logic [6:0]  run;
    logic        is_transparent;
    logic [16:0] run_end;
    logic [15:0] row_inc;

    assign b              = i_item.data_byte;
    assign run            = 7'(b & RUN_LEN_MASK);
    assign is_transparent = (b & RUN_FLAG) != 8'h00;
    assign run_end        = {1'b0, i_ctx.column_count} + {10'd0, run};
    assign row_inc        = i_ctx.row_count + 16'd1;

    always_comb begin
        o_ctx       = i_ctx;
        o_res_valid = 1'b0;
        o_res       = '{pixel: 8'h00, status: ST_OK};

        if (i_item.mode == MODE_START) begin
            if (!(i_item.subimage_index < i_subimage_count)) begin
                o_res_valid = 1'b1;
                o_res.status = ST_BAD_INDEX;
                o_ctx.phase = PH_IDLE;
            end else if (!(i_item.target_x < i_item.sub_width)) begin
                o_res_valid = 1'b1;
                o_res.status = ST_X_OUTSIDE;
                o_ctx.phase = PH_IDLE;
            end else if (!(i_item.target_y < i_item.sub_height)) begin
                o_res_valid = 1'b1;
                o_res.status = ST_Y_OUTSIDE;
                o_ctx.phase = PH_IDLE;
            end else begin
                o_ctx.want_x       = i_item.target_x;
                o_ctx.want_y       = i_item.target_y;
                o_ctx.row_count    = 16'd0;
                o_ctx.column_count = 16'd0;
                o_ctx.literal_left = 7'd0;
                o_ctx.phase        = (i_item.target_y == 16'd0) ? PH_SCAN : PH_SKIP;
            end
        end else begin
            case (i_ctx.phase)
                PH_SKIP: begin
                    if (i_ctx.literal_left != 7'd0) begin
                        o_ctx.literal_left = i_ctx.literal_left - 7'd1;
                    end else if (b == ROW_END) begin
                        o_ctx.row_count = row_inc;
                        if (row_inc == i_ctx.want_y) begin
                            o_ctx.phase        = PH_SCAN;
                            o_ctx.column_count = 16'd0;
                        end
                    end else if (!is_transparent) begin
                        o_ctx.literal_left = run;
                    end
                end
                PH_SCAN: begin
                    if (i_ctx.literal_left != 7'd0) begin
                        if (i_ctx.column_count == i_ctx.want_x) begin
                            o_res_valid = 1'b1;
                            o_res.pixel = b;
                            o_ctx.phase = PH_IDLE;
                        end else begin
                            o_ctx.column_count = i_ctx.column_count + 16'd1;
                            o_ctx.literal_left = i_ctx.literal_left - 7'd1;
                        end
                    end else if (b == ROW_END) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_ROW_ENDED;
                        o_ctx.phase  = PH_IDLE;
                    end else if (is_transparent) begin
                        if (run_end > {1'b0, i_ctx.want_x}) begin
                            o_res_valid = 1'b1;
                            o_ctx.phase = PH_IDLE;
                        end else begin
                            o_ctx.column_count = run_end[15:0];
                        end
                    end else begin
                        o_ctx.literal_left = run;
                    end
                end
                default: begin
                    // idle or unused phase code: bytes are dropped
                end
            endcase
        end
    end

endmodule

[hw/rtl/rle_sprite_pixel_fetch.sv]
// ----------------------------------------------------------------------------
// rle_sprite_pixel_fetch
// fetches one palette-index pixel out of a run-length-coded sprite subimage
// ----------------------------------------------------------------------------
// A start beat (mode 0) carries the query: subimage index, subimage size and
// the wanted x/y. It is checked against the subimage_count register and the
// size, in that order (index, x, y); a failed check returns an error beat
// right away and leaves the block idle. A good start returns nothing and arms
// the decoder. Data beats (mode 1) then deliver the compressed bytes of the
// subimage one per beat: bit 7 set is a transparent run of length [6:0], a
// nonzero byte with bit 7 clear is a literal run followed by that many pixel
// bytes, and 0 ends a row. Rows above the target are skipped, and in the
// target row the block returns the pixel at target_x (0 when transparent) or
// status 4 when the row ends first. Data beats after a result or while idle
// are dropped; a new start always restarts the lookup. Throughput is one beat
// per clock while the result channel does not stall: each beat is registered,
// stepped through a single level of compare/increment logic against the
// decoder context, and any result lands in the output register; a result
// passes the input register, then the output register, before o_out_valid.
// The context update (counters plus one 17-bit add and compare) is what sets
// the clock rate. subimage_count is written through i_cfg_we/i_cfg_data and
// must only change while no lookup is open.
// ----------------------------------------------------------------------------
module rle_sprite_pixel_fetch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rsf_pkg::t_in_item  i_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rsf_pkg::t_out_item o_out,
    // configuration
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);
    import rsf_pkg::*;

    // input register stage
    logic      r_in_valid;
    t_in_item  r_in;

    // decoder context and config
    t_ctx        r_ctx;
    t_ctx        n_ctx;
    logic [15:0] r_sub_count;

    // result register stage
    logic      r_out_valid;
    t_out_item r_out;

    logic      res_valid;
    t_out_item res;
    logic      step;

    // the registered beat steps when the result slot is free or draining
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    rsf_core u_core (
        .i_ctx            (r_ctx),
        .i_item           (r_in),
        .i_subimage_count (r_sub_count),
        .o_ctx            (n_ctx),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_count <= 16'd0;
        end else if (i_cfg_we) begin
            r_sub_count <= i_cfg_data;
        end
    end

    // input stage: load whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // decoder context advances once per stepped beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{phase: PH_IDLE, row_count: 16'd0, column_count: 16'd0,
                       literal_left: 7'd0, want_x: 16'd0, want_y: 16'd0};
        end else if (step) begin
            r_ctx <= n_ctx;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hw/rtl/rsf_checker.sv]
// ----------------------------------------------------------------------------
// rsf_checker
// port-level checks for the run-length sprite pixel fetch block
// ----------------------------------------------------------------------------
module rsf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rsf_pkg::t_out_item o_out
);
    import rsf_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("result payload changed while stalled");

    // any error status carries a zero pixel
    a_err_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> o_out.pixel == 8'h00)
        else $error("error result with nonzero pixel");

    // status codes stay in the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status <= ST_ROW_ENDED))
        else $error("undefined status code");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind rle_sprite_pixel_fetch rsf_checker u_rsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
